>>> hw/rtl/mpm_pkg.sv
// Shared types and constants for the MDIO PHY management sequencer.
package mpm_pkg;

    // Operation classes seen by the sequencer
    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_LINK = 2'd1,
        OP_AN   = 2'd2,
        OP_CPL  = 2'd3
    } op_t;

    // One classified input item
    typedef struct packed {
        op_t         op;
        logic        io_error;
        logic [15:0] read_data;
    } item_t;

    // Queue status towards the back end
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    // Sequencer phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_SCAN    = 9'b000000010,
        PH_ID2     = 9'b000000100,
        PH_RSTW    = 9'b000001000,
        PH_RSTPOLL = 9'b000010000,
        PH_ANWRITE = 9'b000100000,
        PH_BSR1    = 9'b001000000,
        PH_BSR2    = 9'b010000000,
        PH_SCSR    = 9'b100000000
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Done status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IO      = 2'd1;
    localparam logic [1:0] ST_NODEV   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Speed and duplex codes
    localparam logic [1:0] SPD_UNKNOWN = 2'd0;
    localparam logic [1:0] SPD_10      = 2'd1;
    localparam logic [1:0] SPD_100     = 2'd2;
    localparam logic [1:0] DPX_UNKNOWN = 2'd0;
    localparam logic [1:0] DPX_HALF    = 2'd1;
    localparam logic [1:0] DPX_FULL    = 2'd2;

    // Clause-22 register numbers
    localparam logic [4:0] REG_BMCR = 5'd0;
    localparam logic [4:0] REG_BMSR = 5'd1;
    localparam logic [4:0] REG_ID1  = 5'd2;
    localparam logic [4:0] REG_ID2  = 5'd3;
    localparam logic [4:0] REG_SCSR = 5'h1F;

    // Register values and bits
    localparam logic [15:0] BMCR_SOFT_RESET = 16'h8000;
    localparam logic [15:0] BMCR_AN_RESTART = 16'h1200;
    localparam int          BMCR_RESET_BIT  = 15;
    localparam int          BMSR_LINK_BIT   = 2;
    localparam int          SCSR_AN_DONE    = 12;
    localparam logic [15:0] ID_NONE_LOW     = 16'h0000;
    localparam logic [15:0] ID_NONE_HIGH    = 16'hFFFF;

    // Speed indication field, bits 4:2 of the vendor status register
    localparam logic [2:0] SCSR_10_HALF  = 3'b001;
    localparam logic [2:0] SCSR_100_HALF = 3'b010;
    localparam logic [2:0] SCSR_10_FULL  = 3'b101;
    localparam logic [2:0] SCSR_100_FULL = 3'b110;

    // Reset value of the poll limit register
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  phy_addr;
        logic [4:0]  reg_addr;
        logic [15:0] write_data;
        logic [1:0]  status;
        logic        link_up;
        logic [1:0]  speed;
        logic [1:0]  duplex;
        logic [15:0] id_high;
        logic [15:0] id_low;
    } result_t;

endpackage

>>> hw/rtl/mpm_front.sv
// Input stage: takes transfers from the slave side and classifies them.
module mpm_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_type,
    input  logic                  in_error,
    input  logic [15:0]           in_data,
    input  mpm_pkg::q_status_t    q_status,
    output logic                  push,
    output mpm_pkg::item_t        push_item
);

    logic           valid_reg;
    logic           valid_next;
    mpm_pkg::item_t item_reg;
    mpm_pkg::op_t   op_dec;

    // Request type decode
    always_comb
    begin
        unique case (in_type)
            2'd0:    op_dec = mpm_pkg::OP_INIT;
            2'd1:    op_dec = mpm_pkg::OP_LINK;
            2'd2:    op_dec = mpm_pkg::OP_AN;
            default: op_dec = mpm_pkg::OP_CPL;
        endcase
    end

    // Hand on to the queue whenever it has room
    assign push       = valid_reg && !q_status.full;
    assign in_ready   = !valid_reg || !q_status.full;
    assign push_item  = item_reg;
    assign valid_next = (in_valid && in_ready) || (valid_reg && q_status.full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op        <= op_dec;
            item_reg.io_error  <= in_error;
            item_reg.read_data <= in_data;
        end
    end

endmodule

>>> hw/rtl/mpm_queue.sv
// Two-entry queue between the classifier and the sequencer.
module mpm_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mpm_pkg::item_t     push_item,
    input  logic               pop,
    output mpm_pkg::item_t     head_item,
    output mpm_pkg::q_status_t status
);

    mpm_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign head_item    = entry_reg[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/mpm_back.sv
// Sequencer: steps the PHY management phases and holds the result register.
module mpm_back
#(
    parameter int ADDR_COUNT = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        poll_limit,
    input  mpm_pkg::q_status_t q_status,
    input  mpm_pkg::item_t     item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mpm_pkg::result_t   out_result
);

    localparam int SCAN_W = $clog2(ADDR_COUNT + 1);
    localparam logic [SCAN_W:0] SCAN_END = (SCAN_W + 1)'(ADDR_COUNT);

    mpm_pkg::phase_t   phase_reg, phase_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [SCAN_W:0]   scan_inc;
    logic              any_reg, any_next;
    logic [15:0]       poll_reg, poll_next;
    logic [4:0]        found_reg, found_next;
    logic [15:0]       idf_reg, idf_next;
    logic [15:0]       ids_reg, ids_next;
    logic              out_valid_reg, out_valid_next;
    mpm_pkg::result_t  out_reg;

    logic              res_valid;
    logic [1:0]        res_kind;
    logic [4:0]        res_phy;
    logic [4:0]        res_regnum;
    logic [15:0]       res_wdata;
    logic [1:0]        res_status;
    logic              res_up;
    logic [1:0]        res_speed;
    logic [1:0]        res_duplex;
    logic              err;
    logic [15:0]       d;

    // Take the next item when the result register is free or being drained
    assign pop        = q_status.valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign err        = item.io_error;
    assign d          = item.read_data;
    assign scan_inc   = (SCAN_W + 1)'(scan_reg) + (SCAN_W + 1)'(1);

    // Phase transitions and result selection
    always_comb
    begin
        phase_next = phase_reg;
        scan_next  = scan_reg;
        any_next   = any_reg;
        poll_next  = poll_reg;
        found_next = found_reg;
        idf_next   = idf_reg;
        ids_next   = ids_reg;
        res_valid  = 1'b0;
        res_kind   = mpm_pkg::KIND_READ;
        res_phy    = 5'd0;
        res_regnum = 5'd0;
        res_wdata  = 16'd0;
        res_status = mpm_pkg::ST_OK;
        res_up     = 1'b0;
        res_speed  = mpm_pkg::SPD_UNKNOWN;
        res_duplex = mpm_pkg::DPX_UNKNOWN;

        if (pop)
        begin
            unique case (item.op)
                mpm_pkg::OP_INIT:
                begin
                    scan_next  = '0;
                    any_next   = 1'b0;
                    found_next = 5'd0;
                    idf_next   = 16'd0;
                    ids_next   = 16'd0;
                    phase_next = mpm_pkg::PH_SCAN;
                    res_valid  = 1'b1;
                    res_phy    = 5'd0;
                    res_regnum = mpm_pkg::REG_ID1;
                end
                mpm_pkg::OP_LINK:
                begin
                    phase_next = mpm_pkg::PH_BSR1;
                    res_valid  = 1'b1;
                    res_phy    = found_reg;
                    res_regnum = mpm_pkg::REG_BMSR;
                end
                mpm_pkg::OP_AN:
                begin
                    phase_next = mpm_pkg::PH_ANWRITE;
                    res_valid  = 1'b1;
                    res_kind   = mpm_pkg::KIND_WRITE;
                    res_phy    = found_reg;
                    res_regnum = mpm_pkg::REG_BMCR;
                    res_wdata  = mpm_pkg::BMCR_AN_RESTART;
                end
                default:
                begin
                    // MDIO completion
                    unique case (phase_reg)
                        mpm_pkg::PH_SCAN:
                        begin
                            if (!err)
                            begin
                                any_next = 1'b1;
                            end
                            if (!err && d != mpm_pkg::ID_NONE_LOW
                                && d != mpm_pkg::ID_NONE_HIGH)
                            begin
                                found_next = 5'(scan_reg);
                                idf_next   = d;
                                phase_next = mpm_pkg::PH_ID2;
                                res_valid  = 1'b1;
                                res_phy    = 5'(scan_reg);
                                res_regnum = mpm_pkg::REG_ID2;
                            end
                            else
                            begin
                                scan_next = scan_inc[SCAN_W-1:0];
                                res_valid = 1'b1;
                                if (scan_inc >= SCAN_END)
                                begin
                                    phase_next = mpm_pkg::PH_IDLE;
                                    res_kind   = mpm_pkg::KIND_DONE;
                                    res_phy    = found_reg;
                                    res_status = any_next ? mpm_pkg::ST_NODEV
                                                          : mpm_pkg::ST_IO;
                                end
                                else
                                begin
                                    res_phy    = 5'(scan_inc);
                                    res_regnum = mpm_pkg::REG_ID1;
                                end
                            end
                        end
                        mpm_pkg::PH_ID2:
                        begin
                            res_valid = 1'b1;
                            res_phy   = found_reg;
                            if (err)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_IO;
                            end
                            else
                            begin
                                ids_next   = d;
                                poll_next  = 16'd0;
                                phase_next = mpm_pkg::PH_RSTW;
                                res_kind   = mpm_pkg::KIND_WRITE;
                                res_regnum = mpm_pkg::REG_BMCR;
                                res_wdata  = mpm_pkg::BMCR_SOFT_RESET;
                            end
                        end
                        mpm_pkg::PH_RSTW:
                        begin
                            res_valid = 1'b1;
                            res_phy   = found_reg;
                            if (err)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_IO;
                            end
                            else
                            begin
                                poll_next  = 16'd1;
                                phase_next = mpm_pkg::PH_RSTPOLL;
                                res_regnum = mpm_pkg::REG_BMCR;
                            end
                        end
                        mpm_pkg::PH_RSTPOLL:
                        begin
                            res_valid = 1'b1;
                            res_phy   = found_reg;
                            if (err)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_IO;
                            end
                            else if (!d[mpm_pkg::BMCR_RESET_BIT])
                            begin
                                phase_next = mpm_pkg::PH_ANWRITE;
                                res_kind   = mpm_pkg::KIND_WRITE;
                                res_regnum = mpm_pkg::REG_BMCR;
                                res_wdata  = mpm_pkg::BMCR_AN_RESTART;
                            end
                            else if (poll_reg >= poll_limit)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_TIMEOUT;
                            end
                            else
                            begin
                                poll_next  = poll_reg + 16'd1;
                                res_regnum = mpm_pkg::REG_BMCR;
                            end
                        end
                        mpm_pkg::PH_ANWRITE:
                        begin
                            phase_next = mpm_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res_kind   = mpm_pkg::KIND_DONE;
                            res_phy    = found_reg;
                            res_status = err ? mpm_pkg::ST_IO : mpm_pkg::ST_OK;
                        end
                        mpm_pkg::PH_BSR1:
                        begin
                            res_valid = 1'b1;
                            res_phy   = found_reg;
                            if (err)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_IO;
                            end
                            else
                            begin
                                phase_next = mpm_pkg::PH_BSR2;
                                res_regnum = mpm_pkg::REG_BMSR;
                            end
                        end
                        mpm_pkg::PH_BSR2:
                        begin
                            res_valid = 1'b1;
                            res_phy   = found_reg;
                            if (err)
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                                res_status = mpm_pkg::ST_IO;
                            end
                            else if (!d[mpm_pkg::BMSR_LINK_BIT])
                            begin
                                phase_next = mpm_pkg::PH_IDLE;
                                res_kind   = mpm_pkg::KIND_DONE;
                            end
                            else
                            begin
                                phase_next = mpm_pkg::PH_SCSR;
                                res_regnum = mpm_pkg::REG_SCSR;
                            end
                        end
                        mpm_pkg::PH_SCSR:
                        begin
                            phase_next = mpm_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res_kind   = mpm_pkg::KIND_DONE;
                            res_phy    = found_reg;
                            if (err)
                            begin
                                res_status = mpm_pkg::ST_IO;
                            end
                            else
                            begin
                                res_up = 1'b1;
                                if (d[mpm_pkg::SCSR_AN_DONE])
                                begin
                                    unique case (d[4:2])
                                        mpm_pkg::SCSR_100_FULL:
                                        begin
                                            res_speed  = mpm_pkg::SPD_100;
                                            res_duplex = mpm_pkg::DPX_FULL;
                                        end
                                        mpm_pkg::SCSR_100_HALF:
                                        begin
                                            res_speed  = mpm_pkg::SPD_100;
                                            res_duplex = mpm_pkg::DPX_HALF;
                                        end
                                        mpm_pkg::SCSR_10_FULL:
                                        begin
                                            res_speed  = mpm_pkg::SPD_10;
                                            res_duplex = mpm_pkg::DPX_FULL;
                                        end
                                        mpm_pkg::SCSR_10_HALF:
                                        begin
                                            res_speed  = mpm_pkg::SPD_10;
                                            res_duplex = mpm_pkg::DPX_HALF;
                                        end
                                        default:
                                        begin
                                            res_speed  = mpm_pkg::SPD_UNKNOWN;
                                            res_duplex = mpm_pkg::DPX_UNKNOWN;
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                            // idle: completion dropped
                            phase_next = mpm_pkg::PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    // Result register occupancy
    assign out_valid_next = pop ? res_valid : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mpm_pkg::PH_IDLE;
            scan_reg      <= '0;
            any_reg       <= 1'b0;
            poll_reg      <= 16'd0;
            found_reg     <= 5'd0;
            idf_reg       <= 16'd0;
            ids_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            scan_reg      <= scan_next;
            any_reg       <= any_next;
            poll_reg      <= poll_next;
            found_reg     <= found_next;
            idf_reg       <= idf_next;
            ids_reg       <= ids_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            out_reg.kind       <= res_kind;
            out_reg.phy_addr   <= res_phy;
            out_reg.reg_addr   <= res_regnum;
            out_reg.write_data <= res_wdata;
            out_reg.status     <= res_status;
            out_reg.link_up    <= res_up;
            out_reg.speed      <= res_speed;
            out_reg.duplex     <= res_duplex;
            out_reg.id_high    <= idf_next;
            out_reg.id_low     <= ids_next;
        end
    end

endmodule

>>> hw/rtl/mdio_phy_manager.sv
// Top level of the MDIO PHY management sequencer.
//
// Channel   Direction  Transfer contents
// s_*       in         commands and MDIO completions (tuser: request type)
// m_*       out        MDIO read/write requests and done results (tuser: kind)
// cfg_*     in         reset poll limit, write only
//
// One transfer per cycle is sustained in both directions while m_tready is held high;
// each input costs one sequencer step in the back end, which issues at most one result.
// An input transfer reaches its result through the input stage, the queue and the
// result register.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled master side backs up through the two-entry queue before s_tready
// drops; inputs that give no result never occupy the result register.
module mdio_phy_manager
#(
    parameter int ADDR_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // io_error, read_data[15:0], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // phy_addr, reg_addr, write_data, status,
                                   // link_up, speed, duplex, id_high, id_low, pad
    output logic [1:0]  m_tuser,   // kind[1:0]
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    logic               poll_limit_reg;
    logic [15:0]        poll_limit_q_reg;
    logic               push;
    logic               pop;
    mpm_pkg::item_t     push_item;
    mpm_pkg::item_t     head_item;
    mpm_pkg::q_status_t q_status;
    mpm_pkg::result_t   result;

    // Poll limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_q_reg <= mpm_pkg::POLL_LIMIT_RESET;
            poll_limit_reg   <= 1'b0;
        end
        else
        begin
            poll_limit_reg <= cfg_wen;
            if (cfg_wen)
            begin
                poll_limit_q_reg <= cfg_wdata;
            end
        end
    end

    mpm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_error  (s_tdata[0]),
        .in_data   (s_tdata[16:1]),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    mpm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    mpm_back
    #(
        .ADDR_COUNT (ADDR_COUNT)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_limit (poll_limit_q_reg),
        .q_status   (q_status),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result onto the master side
    assign m_tuser = result.kind;
    assign m_tdata = {7'd0, result.id_low, result.id_high, result.duplex, result.speed,
                      result.link_up, result.status, result.write_data,
                      result.reg_addr, result.phy_addr};

`ifndef SYNTHESIS
    // A held result must not be overwritten by a new step
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !pop)
        else $error("sequencer stepped while result stalled");

    // The queue only pops an entry it holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("pop from empty queue");

    // Input stage stalls only behind a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_status.full)
        else $error("input stalled with queue space");

    // No reserved kind is ever issued
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == mpm_pkg::KIND_READ || m_tuser == mpm_pkg::KIND_WRITE
                      || m_tuser == mpm_pkg::KIND_DONE))
        else $error("reserved result kind");

    // A configuration write lands in the poll limit on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        poll_limit_reg |-> (poll_limit_q_reg == $past(cfg_wdata)))
        else $error("poll limit not updated");
`endif

endmodule

>>> tb/mdio_phy_manager_checker.sv
// Checker for the MDIO PHY manager: watches both stream channels, predicts each result and compares.
module mdio_phy_manager_checker
#(
    parameter int ADDR_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          result_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpm_pkg::*;

    // Own copy of the sequencer state
    phase_t      seq_phase;
    logic [5:0]  scan_addr;
    logic        saw_reply;
    logic [15:0] poll_count;
    logic [4:0]  phy_found;
    logic [15:0] ident_hi;
    logic [15:0] ident_lo;
    logic [15:0] poll_limit;

    // Requests and done results still owed by the block, oldest first
    result_t     predicted_results[$];

    // Every result carries the stored identifier words
    function automatic result_t make_result(logic [1:0] kind, logic [4:0] addr,
                                            logic [4:0] regn, logic [15:0] wdata,
                                            logic [1:0] status, logic up,
                                            logic [1:0] spd, logic [1:0] dpx);
        result_t r;
        r.kind       = kind;
        r.phy_addr   = addr;
        r.reg_addr   = regn;
        r.write_data = wdata;
        r.status     = status;
        r.link_up    = up;
        r.speed      = spd;
        r.duplex     = dpx;
        r.id_high    = ident_hi;
        r.id_low     = ident_lo;
        return r;
    endfunction

    function automatic result_t read_req(logic [4:0] addr, logic [4:0] regn);
        return make_result(KIND_READ, addr, regn, 16'h0000, ST_OK, 1'b0,
                           SPD_UNKNOWN, DPX_UNKNOWN);
    endfunction

    function automatic result_t write_req(logic [4:0] regn, logic [15:0] value);
        return make_result(KIND_WRITE, phy_found, regn, value, ST_OK, 1'b0,
                           SPD_UNKNOWN, DPX_UNKNOWN);
    endfunction

    // Ends the running sequence
    function automatic result_t finish(logic [1:0] status, logic up,
                                       logic [1:0] spd, logic [1:0] dpx);
        seq_phase = PH_IDLE;
        return make_result(KIND_DONE, phy_found, 5'd0, 16'h0000, status, up, spd, dpx);
    endfunction

    // One sequencer step; returns 1 when the input gives a result
    function automatic bit sequencer_step(input op_t op, input logic err,
                                          input logic [15:0] d, output result_t r);
        logic [1:0] spd;
        logic [1:0] dpx;
        r   = '0;
        spd = SPD_UNKNOWN;
        dpx = DPX_UNKNOWN;

        // Commands start at once, whatever is running
        if (op == OP_INIT) begin
            scan_addr = '0;
            saw_reply = 1'b0;
            phy_found = '0;
            ident_hi  = '0;
            ident_lo  = '0;
            seq_phase = PH_SCAN;
            r = read_req(5'd0, REG_ID1);
            return 1'b1;
        end
        if (op == OP_LINK) begin
            seq_phase = PH_BSR1;
            r = read_req(phy_found, REG_BMSR);
            return 1'b1;
        end
        if (op == OP_AN) begin
            seq_phase = PH_ANWRITE;
            r = write_req(REG_BMCR, BMCR_AN_RESTART);
            return 1'b1;
        end

        // MDIO completion
        case (seq_phase)
            PH_SCAN:
            begin
                if (!err) begin
                    saw_reply = 1'b1;
                    if (d != ID_NONE_LOW && d != ID_NONE_HIGH) begin
                        phy_found = scan_addr[4:0];
                        ident_hi  = d;
                        seq_phase = PH_ID2;
                        r = read_req(phy_found, REG_ID2);
                        return 1'b1;
                    end
                end
                scan_addr = scan_addr + 6'd1;
                if (scan_addr >= ADDR_COUNT)
                    r = finish(saw_reply ? ST_NODEV : ST_IO, 1'b0, spd, dpx);
                else
                    r = read_req(scan_addr[4:0], REG_ID1);
                return 1'b1;
            end
            PH_ID2:
            begin
                if (err) begin
                    r = finish(ST_IO, 1'b0, spd, dpx);
                    return 1'b1;
                end
                ident_lo   = d;
                poll_count = '0;
                seq_phase  = PH_RSTW;
                r = write_req(REG_BMCR, BMCR_SOFT_RESET);
                return 1'b1;
            end
            PH_RSTW:
            begin
                if (err) begin
                    r = finish(ST_IO, 1'b0, spd, dpx);
                    return 1'b1;
                end
                poll_count = 16'd1;
                seq_phase  = PH_RSTPOLL;
                r = read_req(phy_found, REG_BMCR);
                return 1'b1;
            end
            PH_RSTPOLL:
            begin
                if (err)
                    r = finish(ST_IO, 1'b0, spd, dpx);
                else if (!d[BMCR_RESET_BIT]) begin
                    seq_phase = PH_ANWRITE;
                    r = write_req(REG_BMCR, BMCR_AN_RESTART);
                end
                else if (poll_count >= poll_limit)
                    r = finish(ST_TIMEOUT, 1'b0, spd, dpx);
                else begin
                    poll_count = poll_count + 16'd1;
                    r = read_req(phy_found, REG_BMCR);
                end
                return 1'b1;
            end
            PH_ANWRITE:
            begin
                r = finish(err ? ST_IO : ST_OK, 1'b0, spd, dpx);
                return 1'b1;
            end
            PH_BSR1:
            begin
                if (err)
                    r = finish(ST_IO, 1'b0, spd, dpx);
                else begin
                    seq_phase = PH_BSR2;
                    r = read_req(phy_found, REG_BMSR);
                end
                return 1'b1;
            end
            PH_BSR2:
            begin
                if (err)
                    r = finish(ST_IO, 1'b0, spd, dpx);
                else if (!d[BMSR_LINK_BIT])
                    r = finish(ST_OK, 1'b0, spd, dpx);
                else begin
                    seq_phase = PH_SCSR;
                    r = read_req(phy_found, REG_SCSR);
                end
                return 1'b1;
            end
            PH_SCSR:
            begin
                if (err) begin
                    r = finish(ST_IO, 1'b0, spd, dpx);
                    return 1'b1;
                end
                // Speed and duplex only count once autoneg has finished
                if (d[SCSR_AN_DONE]) begin
                    case (d[4:2])
                        SCSR_100_FULL:
                        begin
                            spd = SPD_100;
                            dpx = DPX_FULL;
                        end
                        SCSR_100_HALF:
                        begin
                            spd = SPD_100;
                            dpx = DPX_HALF;
                        end
                        SCSR_10_FULL:
                        begin
                            spd = SPD_10;
                            dpx = DPX_FULL;
                        end
                        SCSR_10_HALF:
                        begin
                            spd = SPD_10;
                            dpx = DPX_HALF;
                        end
                        default: ;
                    endcase
                end
                r = finish(ST_OK, 1'b1, spd, dpx);
                return 1'b1;
            end
            default:
            begin
                // Completion with nothing running is dropped
                seq_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    endfunction

    // Compare one output transfer with the oldest prediction
    task automatic check_result(input result_t got);
        result_t want;
        if (predicted_results.size() == 0) begin
            fail_count++;
            $display("%0t: result with none expected: expected nothing, got 0x%h",
                     $time, got);
            return;
        end
        want = predicted_results.pop_front();
        if (got !== want) begin
            fail_count++;
            report_field("kind", want.kind, got.kind);
            report_field("phy_addr", want.phy_addr, got.phy_addr);
            report_field("reg_addr", want.reg_addr, got.reg_addr);
            report_field("write_data", want.write_data, got.write_data);
            report_field("status", want.status, got.status);
            report_field("link_up", want.link_up, got.link_up);
            report_field("speed", want.speed, got.speed);
            report_field("duplex", want.duplex, got.duplex);
            report_field("id_high", want.id_high, got.id_high);
            report_field("id_low", want.id_low, got.id_low);
        end
    endtask

    // Sample both channels and the register port at every rising edge
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n) begin
            seq_phase    = PH_IDLE;
            scan_addr    = '0;
            saw_reply    = 1'b0;
            poll_count   = '0;
            phy_found    = '0;
            ident_hi     = '0;
            ident_lo     = '0;
            poll_limit   = POLL_LIMIT_RESET;
            fail_count   = 0;
            result_count = 0;
            predicted_results.delete();
        end
        else begin
            if (cfg_wen)
                poll_limit = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got.kind       = m_tuser;
                got.phy_addr   = m_tdata[4:0];
                got.reg_addr   = m_tdata[9:5];
                got.write_data = m_tdata[25:10];
                got.status     = m_tdata[27:26];
                got.link_up    = m_tdata[28];
                got.speed      = m_tdata[30:29];
                got.duplex     = m_tdata[32:31];
                got.id_high    = m_tdata[48:33];
                got.id_low     = m_tdata[64:49];
                check_result(got);
                result_count++;
            end
            if (s_tvalid && s_tready) begin
                if (sequencer_step(op_t'(s_tuser), s_tdata[0], s_tdata[16:1], want))
                    predicted_results.push_back(want);
            end
        end
        pending = predicted_results.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top for the MDIO PHY manager: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mpm_pkg::*;

    localparam int ADDR_COUNT   = 32;
    localparam int LATENCY      = 3;
    localparam int LONG_HOLD    = 120;
    localparam int RANDOM_ITEMS = 1300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int fail_count;
    int result_count;
    int pending;
    int items_sent     = 0;
    int settings_used  = 1;
    int hold_requests  = 0;
    int holds_granted  = 0;
    int steady_left    = 0;
    int trunc_left     = -1;

    mdio_phy_manager #(.ADDR_COUNT(ADDR_COUNT)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    mdio_phy_manager_checker #(.ADDR_COUNT(ADDR_COUNT)) seq_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .result_count (result_count),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    // Idle length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_left > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Rare MDIO failure inside an otherwise good sequence
    function automatic logic flaky();
        return ($urandom_range(0, 39) == 0);
    endfunction

    function automatic logic [15:0] rand_ident();
        logic [15:0] v;
        do
            v = 16'($urandom);
        while (v == ID_NONE_LOW || v == ID_NONE_HIGH);
        return v;
    endfunction

    // One input transfer, after an optional idle gap
    task automatic send_item(input op_t op, input logic err, input logic [15:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, data, err};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (steady_left > 0)
            steady_left--;
    endtask

    // Commands carry random payload bits, which the block must ignore
    task automatic send_cmd(input op_t op);
        send_item(op, 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    // Completion; a truncated sequence drops the rest of its completions
    task automatic send_cpl(input logic err, input logic [15:0] data);
        if (trunc_left == 0)
            return;
        if (trunc_left > 0)
            trunc_left--;
        send_item(OP_CPL, err, data);
    endtask

    // Init: address scan, identifier, soft reset with polling, autoneg restart
    task automatic run_init();
        int mode;
        int misses;
        int polls;
        int r;
        mode = $urandom_range(0, 19);
        send_cmd(OP_INIT);
        if (mode < 2)
            misses = ADDR_COUNT;
        else if (mode < 5)
            misses = $urandom_range(4, ADDR_COUNT - 1);
        else
            misses = $urandom_range(0, 3);
        // Addresses with no usable identifier; mode 0 fails every read
        for (int i = 0; i < misses; i++) begin
            if (mode == 0 || $urandom_range(0, 2) == 0)
                send_cpl(1'b1, 16'($urandom));
            else
                send_cpl(1'b0, $urandom_range(0, 1) ? ID_NONE_HIGH : ID_NONE_LOW);
        end
        if (misses >= ADDR_COUNT)
            return;
        send_cpl(flaky(), rand_ident());
        send_cpl(flaky(), 16'($urandom));
        send_cpl(flaky(), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 70)
            polls = $urandom_range(0, 3);
        else if (r < 95)
            polls = $urandom_range(4, 10);
        else
            polls = $urandom_range(11, 40);
        for (int i = 0; i < polls; i++)
            send_cpl(flaky(), 16'($urandom) | BMCR_SOFT_RESET);
        send_cpl(flaky(), 16'($urandom) & ~BMCR_SOFT_RESET);
        send_cpl(flaky(), 16'($urandom));
    endtask

    // Link poll: status read twice, then the vendor register when the link is up
    task automatic run_link();
        logic [15:0] v;
        logic        up;
        send_cmd(OP_LINK);
        send_cpl(flaky(), 16'($urandom));
        up = ($urandom_range(0, 3) != 0);
        v = 16'($urandom);
        v[BMSR_LINK_BIT] = up;
        send_cpl(flaky(), v);
        if (!up)
            return;
        v = 16'($urandom);
        v[SCSR_AN_DONE] = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 4))
            0: v[4:2] = SCSR_10_HALF;
            1: v[4:2] = SCSR_100_HALF;
            2: v[4:2] = SCSR_10_FULL;
            3: v[4:2] = SCSR_100_FULL;
            default: ;
        endcase
        send_cpl(flaky(), v);
    endtask

    task automatic run_an();
        send_cmd(OP_AN);
        send_cpl(flaky(), 16'($urandom));
    endtask

    // Mostly well-formed sequences, some cut short, some pure noise
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if (steady_left == 0 && $urandom_range(0, 15) == 0)
                steady_left = $urandom_range(20, 40);
            trunc_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : -1;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                run_init();
            else if (pick < 72)
                run_link();
            else if (pick < 85)
                run_an();
            else begin
                trunc_left = -1;
                repeat ($urandom_range(1, 3))
                    send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              16'($urandom));
            end
        end
        trunc_left = -1;
    endtask

    // Let the block drain completely before touching the register
    task automatic write_poll_limit(input logic [15:0] value);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        settings_used++;
    endtask

    // Output side: random stalls, plus long holds on request
    initial
    begin : receiver
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (holds_granted < hold_requests) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_granted++;
            end
            else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("mdio_phy_manager test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] poll_limits [6];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Completion with nothing running is dropped
        send_cpl(1'b1, 16'hFFFF);
        // Link poll before any init uses address zero; 100 Mb/s full duplex
        send_cmd(OP_LINK);
        send_cpl(1'b0, 16'h0000);
        send_cpl(1'b0, 16'h0004);
        send_cpl(1'b0, 16'h1018);
        // Autoneg restart before init, write fails
        send_cmd(OP_AN);
        send_cpl(1'b1, 16'h0000);
        // Init: failed read, two empty addresses, PHY at address 3, one busy poll
        send_cmd(OP_INIT);
        send_cpl(1'b1, 16'h5555);
        send_cpl(1'b0, 16'hFFFF);
        send_cpl(1'b0, 16'h0000);
        send_cpl(1'b0, 16'hABCD);
        send_cpl(1'b0, 16'h1234);
        send_cpl(1'b0, 16'h0000);
        send_cpl(1'b0, 16'h8000);
        send_cpl(1'b0, 16'h0000);
        send_cpl(1'b0, 16'h0000);
        // Init abandons a running link poll, then the second identifier read fails
        send_cmd(OP_LINK);
        send_cpl(1'b0, 16'h0004);
        send_cmd(OP_INIT);
        send_cpl(1'b0, 16'h7FFF);
        send_cpl(1'b1, 16'hFFFF);
        // Link poll with a failed status read
        send_cmd(OP_LINK);
        send_cpl(1'b1, 16'hFFFF);

        // Random part over several poll limits, zero and all-ones among them
        poll_limits = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'($urandom_range(1, 10))};
        foreach (poll_limits[k]) begin
            write_poll_limit(poll_limits[k]);
            if (k == 1 || k == 4) begin
                hold_requests++;
                steady_left = 60;
            end
            run_random(RANDOM_ITEMS / 6);
        end

        // Drain, then allow for the pipeline
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (LATENCY + 5) @(posedge clk);

        $display("Covered %0d input transfers and %0d checked results under %0d poll limits,",
                 items_sent, result_count, settings_used);
        $display("with %0d long output holds and random idling on both sides.", holds_granted);
        if (fail_count == 0)
            $display("mdio_phy_manager test passed");
        else
            $display("mdio_phy_manager test failed");
        $finish;
    end

endmodule
